// File: sv/crc16_checked_frame_sync_unit_macros.svh
// assertion macros shared by the frame sync checker
`ifndef CRC16_CHECKED_FRAME_SYNC_UNIT_MACROS_SVH
`define CRC16_CHECKED_FRAME_SYNC_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk and quiet in reset
`define CRCFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk and quiet in reset
`define CRCFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/crcfs_pkg.sv
// shared types and constants of the crc16 frame sync unit
package crcfs_pkg;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'h0000;

  // control of the bit-serial crc unit
  typedef struct packed {
    logic clear;
    logic load;
    logic step;
  } crc_ctrl_t;

endpackage

// File: sv/crcfs_ram.sv
// generic single write port ram with registered read
module crcfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem_r[rd_addr];
  end

endmodule

// File: sv/crcfs_crc_bit.sv
// bit-serial crc-16 engine, msb first, one bit per cycle while ctrl.step is set
module crcfs_crc_bit
  import crcfs_pkg::*;
(
  input  logic        clk,
  input  crc_ctrl_t   ctrl,
  input  logic [7:0]  byte_in,
  output logic [15:0] crc
);

  logic [15:0] crc_r;
  logic [7:0]  shift_r;
  logic        fb;

  // feedback of the top crc bit against the next data bit
  assign fb  = crc_r[15] ^ shift_r[7];
  assign crc = crc_r;

  // crc register and data shifter
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      crc_r <= CRC_INIT;
    end else if (ctrl.step) begin
      crc_r <= {crc_r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    if (ctrl.load) begin
      shift_r <= byte_in;
    end else if (ctrl.step) begin
      shift_r <= {shift_r[6:0], 1'b0};
    end
  end

endmodule

// File: sv/crc16_checked_frame_sync_unit.sv
// frame sync unit: start byte hunt, frame buffer, crc-16 check, frame output
// a byte that does not complete a frame is taken and the unit stays idle; a
// completing byte starts a check that loads each body byte and shifts it
// through the crc bit by bit, then compares the two trailer bytes
// a good frame then emits FRAME_BYTES-2 bytes; a bad frame rescans the buffer
// reset (rst_n low, synchronous) empties the buffer and clears start_byte to 0
module crc16_checked_frame_sync_unit
  import crcfs_pkg::*;
#(
  parameter int FRAME_BYTES = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_frame_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_start_byte
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam logic [AW-1:0] HI_OFF   = AW'(FRAME_BYTES - 2);
  localparam logic [AW-1:0] LO_OFF   = AW'(FRAME_BYTES - 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(FRAME_BYTES - 3);
  localparam logic [AW-1:0] TOP_IDX  = AW'(FRAME_BYTES - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(FRAME_BYTES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CRC_RD,
    ST_CRC_LD,
    ST_CRC_SH,
    ST_HI_RD,
    ST_HI_LD,
    ST_CMP,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_OUT,
    ST_SCAN_RD,
    ST_SCAN_CMP
  } state_t;

  state_t        state_r;
  logic [7:0]    start_byte_r;
  logic [AW-1:0] head_r;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [2:0]    bit_cnt_r;
  logic [7:0]    got_hi_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_last_r;

  logic          in_acc;
  logic          keep_byte;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  crc_ctrl_t     crc_ctrl;
  logic [15:0]   crc;
  logic [AW-1:0] head_inc;

  // circular index add, both operands below FRAME_BYTES
  function automatic logic [AW-1:0] add_wrap(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (AW+1)'(FRAME_BYTES)) begin
      s = s - (AW+1)'(FRAME_BYTES);
    end
    return s[AW-1:0];
  endfunction

  // handshake and write side
  assign cfg_ready      = (state_r == ST_IDLE);
  assign in_ready       = (state_r == ST_IDLE);
  assign in_acc         = in_valid && in_ready;
  assign keep_byte      = (count_r != '0) || (in_rx_byte == start_byte_r);
  assign wr_en          = in_acc && keep_byte;
  assign wr_addr        = add_wrap(head_r, count_r[AW-1:0]);
  assign head_inc       = (head_r == TOP_IDX) ? '0 : head_r + AW'(1);
  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_frame_last = out_last_r;

  // read address per state
  always_comb begin
    unique case (state_r)
      ST_CRC_RD:  rd_addr = add_wrap(head_r, idx_r);
      ST_HI_RD:   rd_addr = add_wrap(head_r, HI_OFF);
      ST_HI_LD:   rd_addr = add_wrap(head_r, LO_OFF);
      ST_EMIT_RD: rd_addr = add_wrap(head_r, idx_r);
      default:    rd_addr = head_r;
    endcase
  end

  // crc unit control
  always_comb begin
    crc_ctrl.clear = (state_r == ST_IDLE);
    crc_ctrl.load  = (state_r == ST_CRC_LD);
    crc_ctrl.step  = (state_r == ST_CRC_SH);
  end

  crcfs_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_BYTES)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (in_rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  crcfs_crc_bit u_crc (
    .clk     (clk),
    .ctrl    (crc_ctrl),
    .byte_in (rd_data),
    .crc     (crc)
  );

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r <= 8'h00;
    end else if (cfg_valid && cfg_ready) begin
      start_byte_r <= cfg_start_byte;
    end
  end

  // frame sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      bit_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (wr_en) begin
            count_r <= count_r + CW'(1);
            idx_r   <= '0;
            if (count_r + CW'(1) == FULL_CNT) begin
              state_r <= ST_CRC_RD;
            end
          end
        end
        ST_CRC_RD: begin
          state_r <= ST_CRC_LD;
        end
        ST_CRC_LD: begin
          bit_cnt_r <= '0;
          state_r   <= ST_CRC_SH;
        end
        ST_CRC_SH: begin
          bit_cnt_r <= bit_cnt_r + 3'd1;
          if (bit_cnt_r == 3'd7) begin
            if (idx_r == LAST_IDX) begin
              state_r <= ST_HI_RD;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= ST_CRC_RD;
            end
          end
        end
        ST_HI_RD: begin
          state_r <= ST_HI_LD;
        end
        ST_HI_LD: begin
          got_hi_r <= rd_data;
          state_r  <= ST_CMP;
        end
        ST_CMP: begin
          if ({got_hi_r, rd_data} == crc) begin
            idx_r   <= '0;
            state_r <= ST_EMIT_RD;
          end else begin
            // drop the first byte, then hunt for the next start byte
            head_r  <= head_inc;
            count_r <= count_r - CW'(1);
            state_r <= ST_SCAN_RD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          out_byte_r  <= rd_data;
          out_last_r  <= (idx_r == LAST_IDX);
          out_valid_r <= 1'b1;
          state_r     <= ST_EMIT_OUT;
        end
        ST_EMIT_OUT: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            if (out_last_r) begin
              head_r  <= '0;
              count_r <= '0;
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + AW'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        ST_SCAN_RD: begin
          if (count_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            state_r <= ST_SCAN_CMP;
          end
        end
        ST_SCAN_CMP: begin
          if (rd_data == start_byte_r) begin
            state_r <= ST_IDLE;
          end else begin
            head_r  <= head_inc;
            count_r <= count_r - CW'(1);
            state_r <= ST_SCAN_RD;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/crcfs_checker.sv
// port-level checker for the frame sync unit, bound to the top level
`include "crc16_checked_frame_sync_unit_macros.svh"

module crcfs_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_frame_last
);

  // a stalled output request keeps its payload
  `CRCFS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out_frame_byte) && $stable(out_frame_last),
    "output request changed while stalled")

  // no new byte is taken while a frame is being emitted
  `CRCFS_ASSERT_NOW(a_no_in_during_out, out_valid, !in_ready, "input taken during frame output")

  // the last byte of a frame closes the run
  `CRCFS_ASSERT_NEXT(a_last_closes, out_valid && out_ready && out_frame_last, !out_valid,
    "output continued after last byte")

  // every accepted output request is followed by a read gap
  `CRCFS_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid,
    "back-to-back output without read gap")

endmodule

bind crc16_checked_frame_sync_unit crcfs_checker u_crcfs_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_frame_last (out_frame_last)
);

// File: tb/crc16_checked_frame_sync_unit_tb.sv
// self-checking testbench for the crc-16 checked frame sync unit
`timescale 1ns / 1ps

module crc16_checked_frame_sync_unit_tb
  import crcfs_pkg::*;
();

  localparam int FRAME_BYTES = 32;
  localparam int BODY_BYTES = FRAME_BYTES - 2;
  // worst case check plus rescan, with margin
  localparam int SETTLE_CYCLES = 12 * FRAME_BYTES + 64;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_ITEMS = 32;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  typedef enum int {
    RX_READY_ALWAYS,
    RX_READY_COIN,
    RX_READY_EVERY_FOURTH,
    RX_READY_RARE
  } ready_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_frame_byte;
  logic       out_frame_last;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_start_byte = 8'h00;

  // predictor state
  logic [7:0] held_bytes [FRAME_BYTES];
  int         held_count = 0;
  logic [7:0] sync_start_byte = 8'h00;

  logic [7:0] rx_stream_q [$];
  frame_out_t checked_bytes_q [$];
  int         error_count = 0;

  // frame scratch for stimulus building
  logic [7:0] frame_buf [FRAME_BYTES];
  logic [7:0] scan_buf [FRAME_BYTES];

  int          burst_left = 0;
  int          gap_left = 0;
  ready_mode_t ready_mode = RX_READY_ALWAYS;
  int          ready_span = 0;
  int          ready_tick = 0;
  int          quiet_cycles = 0;

  crc16_checked_frame_sync_unit #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_rx_byte    (in_rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_frame_byte(out_frame_byte),
    .out_frame_last(out_frame_last),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_start_byte(cfg_start_byte)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // crc-16 msb first over the frame body
  function automatic logic [15:0] crc16_xmodem(input logic [7:0] data [FRAME_BYTES]);
    logic [15:0] crc;
    int k;
    int b;
    crc = CRC_INIT;
    for (k = 0; k < BODY_BYTES; k++) begin
      crc = crc ^ {data[k], 8'h00};
      for (b = 0; b < 8; b++) begin
        if (crc[15]) begin
          crc = (crc << 1) ^ CRC_POLY;
        end else begin
          crc = crc << 1;
        end
      end
    end
    return crc;
  endfunction

  // hunt, gather and check one accepted byte, queueing the body of any good frame it completes
  task automatic absorb_rx_byte(input logic [7:0] rx);
    logic [15:0] trailer;
    frame_out_t  res;
    int k;
    int j;
    if (held_count == 0 && rx != sync_start_byte) return;
    held_bytes[held_count] = rx;
    held_count++;
    if (held_count < FRAME_BYTES) return;
    trailer = {held_bytes[BODY_BYTES], held_bytes[BODY_BYTES + 1]};
    if (crc16_xmodem(held_bytes) == trailer) begin
      for (k = 0; k < BODY_BYTES; k++) begin
        res.data = held_bytes[k];
        res.last = (k == BODY_BYTES - 1);
        checked_bytes_q.push_back(res);
      end
      held_count = 0;
    end else begin
      // drop the first byte, then slide to the next start byte
      do begin
        for (j = 0; j < held_count - 1; j++) held_bytes[j] = held_bytes[j + 1];
        held_count--;
      end while (held_count > 0 && held_bytes[0] != sync_start_byte);
    end
  endtask

  // input driver: bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) absorb_rx_byte(in_rx_byte);
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (rx_stream_q.size() != 0) begin
          in_valid <= 1'b1;
          in_rx_byte <= rx_stream_q.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern, switching to a random mode at the end of each random span
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      ready_span <= 0;
      ready_tick <= 0;
    end else begin
      ready_tick <= ready_tick + 1;
      if (ready_span == 0) begin
        ready_mode <= ready_mode_t'($urandom_range(0, 3));
        ready_span <= $urandom_range(16, 96);
      end else begin
        ready_span <= ready_span - 1;
      end
      case (ready_mode)
        RX_READY_ALWAYS:       out_ready <= 1'b1;
        RX_READY_COIN:         out_ready <= 1'($urandom_range(0, 1));
        RX_READY_EVERY_FOURTH: out_ready <= (ready_tick % 4 == 0);
        default:               out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // result monitor
  always @(posedge clk) begin : frame_monitor
    frame_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (checked_bytes_q.size() == 0) begin
        $error("unexpected frame byte %0h (last %0b)", out_frame_byte, out_frame_last);
        error_count++;
      end else begin
        want = checked_bytes_q.pop_front();
        if (out_frame_byte !== want.data) begin
          $error("frame_byte: expected %0h, got %0h", want.data, out_frame_byte);
          error_count++;
        end
        if (out_frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, out_frame_last);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no request moved on any channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("crc16_checked_frame_sync_unit_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // start byte register write
  task automatic write_start_byte(input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_start_byte <= value;
    do @(posedge clk); while (!cfg_ready);
    sync_start_byte = value;
    cfg_valid <= 1'b0;
  endtask

  // wait for the stream and results to drain, then for any check still running
  task automatic wait_until_idle();
    while (rx_stream_q.size() != 0 || in_valid || checked_bytes_q.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic build_frame(input logic [7:0] lead);
    int i;
    frame_buf[0] = lead;
    for (i = 1; i < BODY_BYTES; i++) frame_buf[i] = 8'($urandom_range(0, 255));
  endtask

  task automatic seal_frame();
    logic [15:0] crc;
    crc = crc16_xmodem(frame_buf);
    frame_buf[BODY_BYTES] = crc[15:8];
    frame_buf[BODY_BYTES + 1] = crc[7:0];
  endtask

  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(1, FRAME_BYTES - 1);
    frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(0, 7));
  endtask

  task automatic push_frame_span(input int lo, input int hi);
    int i;
    for (i = lo; i <= hi; i++) rx_stream_q.push_back(frame_buf[i]);
  endtask

  task automatic push_noise(input int n);
    int i;
    for (i = 0; i < n; i++) rx_stream_q.push_back(8'($urandom_range(0, 255)));
  endtask

  // bad frame whose tail, from a start byte at offset k, opens a good frame
  task automatic queue_rescan_case(input logic [7:0] lead, input int k);
    logic [15:0] crc;
    int i;
    build_frame(lead);
    seal_frame();
    scan_buf[0] = lead;
    for (i = 1; i < k; i++) begin
      scan_buf[i] = 8'($urandom_range(0, 255));
      if (scan_buf[i] == lead) scan_buf[i] = ~lead;
    end
    for (i = k; i < FRAME_BYTES; i++) scan_buf[i] = frame_buf[i - k];
    crc = crc16_xmodem(scan_buf);
    if (crc == {scan_buf[BODY_BYTES], scan_buf[BODY_BYTES + 1]})
      scan_buf[1] = scan_buf[1] ^ 8'h80;
    for (i = 0; i < FRAME_BYTES; i++) rx_stream_q.push_back(scan_buf[i]);
    push_frame_span(FRAME_BYTES - k, FRAME_BYTES - 1);
  endtask

  // random mix of good, bad, rescanning frames and line noise
  task automatic run_random_phase(input logic [7:0] start_value);
    int counted;
    int pick;
    int k;
    counted = 0;
    write_start_byte(start_value);
    while (counted < PHASE_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        build_frame(start_value);
        seal_frame();
        push_frame_span(0, FRAME_BYTES - 1);
        counted += FRAME_BYTES;
      end else if (pick < 70) begin
        build_frame(start_value);
        seal_frame();
        corrupt_frame();
        push_frame_span(0, FRAME_BYTES - 1);
        counted += FRAME_BYTES;
      end else if (pick < 82) begin
        k = $urandom_range(2, FRAME_BYTES - 1);
        queue_rescan_case(start_value, k);
        counted += FRAME_BYTES + k;
      end else begin
        push_noise($urandom_range(1, 6));
      end
    end
    wait_until_idle();
  endtask

  initial begin : stimulus
    int i;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset start byte of zero: noise, an all-zero frame, an alternating frame
    rx_stream_q.push_back(8'h01);
    rx_stream_q.push_back(8'hFF);
    rx_stream_q.push_back(8'h80);
    rx_stream_q.push_back(8'h7F);
    for (i = 0; i < BODY_BYTES; i++) frame_buf[i] = 8'h00;
    seal_frame();
    push_frame_span(0, FRAME_BYTES - 1);
    for (i = 1; i < BODY_BYTES; i++) frame_buf[i] = i[0] ? 8'hFF : 8'h00;
    frame_buf[0] = 8'h00;
    seal_frame();
    push_frame_span(0, FRAME_BYTES - 1);
    wait_until_idle();

    // top start byte: all-ones frame, bad frame, rescan into a good frame
    write_start_byte(8'hFF);
    rx_stream_q.push_back(8'h00);
    rx_stream_q.push_back(8'hFE);
    for (i = 0; i < BODY_BYTES; i++) frame_buf[i] = 8'hFF;
    seal_frame();
    push_frame_span(0, FRAME_BYTES - 1);
    build_frame(8'hFF);
    for (i = 1; i < BODY_BYTES; i++) if (frame_buf[i] == 8'hFF) frame_buf[i] = 8'h5A;
    seal_frame();
    frame_buf[BODY_BYTES + 1] = frame_buf[BODY_BYTES + 1] ^ 8'h01;
    push_frame_span(0, FRAME_BYTES - 1);
    queue_rescan_case(8'hFF, 5);
    wait_until_idle();

    // start byte changed mid-frame keeps the bytes already held
    write_start_byte(8'h3C);
    build_frame(8'h3C);
    seal_frame();
    push_frame_span(0, 11);
    wait_until_idle();
    write_start_byte(8'hC3);
    push_frame_span(12, FRAME_BYTES - 1);
    wait_until_idle();

    // random phases over several start byte settings
    run_random_phase(8'h00);
    run_random_phase(8'hFF);
    run_random_phase(8'($urandom_range(1, 254)));
    run_random_phase(8'($urandom_range(1, 254)));
    run_random_phase(8'($urandom_range(1, 254)));

    if (error_count == 0) begin
      $display("crc16_checked_frame_sync_unit_tb: done, clean");
    end else begin
      $display("crc16_checked_frame_sync_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
